// ===== rtl/rbvg_pkg.sv =====
// Package for the rounded box vertex generator: widths, codes, arc table, shared types.
// Used by every module in rtl/.
package rbvg_pkg;

  localparam int ARC_POINTS_DEF = 9;
  localparam int FRAC_BITS_DEF = 8;
  localparam int COORD_W = 22;
  localparam int SCALE_W = 12;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_OUTLINE = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Arc table entries, scaled by 1024.
  function automatic logic [10:0] arc_a(input logic [3:0] i);
    logic [10:0] v;
    unique case (i)
      4'd0: v = 11'd0;
      4'd1: v = 11'd200;
      4'd2: v = 11'd392;
      4'd3: v = 11'd563;
      4'd4: v = 11'd724;
      4'd5: v = 11'd851;
      4'd6: v = 11'd946;
      4'd7: v = 11'd1004;
      default: v = 11'd1024;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] arc_b(input logic [3:0] i);
    logic [10:0] v;
    unique case (i)
      4'd0: v = 11'd0;
      4'd1: v = 11'd20;
      4'd2: v = 11'd69;
      4'd3: v = 11'd173;
      4'd4: v = 11'd300;
      4'd5: v = 11'd461;
      4'd6: v = 11'd632;
      4'd7: v = 11'd824;
      default: v = 11'd1024;
    endcase
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [47:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 48'sd2097151) r = 22'sd2097151;
    else if (v < -48'sd2097152) r = -22'sd2097152;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  typedef struct packed {
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic [7:0]  border_width;
    logic [3:0]  corner_mask;
    logic [9:0]  corner_radius;
  } req_t;

  typedef struct packed {
    logic [1:0]  vertex_kind;
    logic [5:0]  vertex_index;
    logic signed [COORD_W-1:0] inner_x;
    logic signed [COORD_W-1:0] inner_y;
    logic signed [COORD_W-1:0] outer_x;
    logic signed [COORD_W-1:0] outer_y;
    logic        outer_valid;
    logic        half_end;
    logic        last_item;
  } vtx_t;

endpackage

// ===== rtl/rounded_box_vertex_generator.sv =====
// Rounded box vertex generator top level: queue, set-up front, vertex walker.
// An accepted word passes the queue, the set-up states and the walker start before its fan center word.
// Each request yields N+2 output words (N = 4..36 outline words): center, N outline, close;
// the set-up takes a further request only after the close word of the last one is accepted.
// Reset (rst, synchronous) empties the queue and sets pixel_scale to 256.
module rounded_box_vertex_generator import rbvg_pkg::*; #(
  parameter int ARC_POINTS = ARC_POINTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // box_width[11:0], box_height[23:12], border_width[31:24], corner_mask[35:32],
  // corner_radius[45:36], zero pad to 48
  input  logic [47:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // vertex_index[5:0], inner_x[27:6], inner_y[49:28], outer_x[71:50],
  // outer_y[93:72], half_end[94], zero pad to 96
  output logic [95:0] m_tdata,
  // vertex_kind[1:0], outer_valid[2]
  output logic [2:0] m_tuser,
  output logic m_tlast
);
  logic [SCALE_W-1:0] pixel_scale;
  req_t in_req, q_req;
  logic q_valid, q_ready, go, done;
  logic signed [31:0] rad, radi, bs, wf, hf;
  vtx_t vtx;

  always_ff @(posedge clk) begin
    if (rst) pixel_scale <= SCALE_RESET;
    else if (cfg_we) pixel_scale <= cfg_wdata;
  end

  assign in_req = '{s_tdata[11:0], s_tdata[23:12], s_tdata[31:24],
                    s_tdata[35:32], s_tdata[45:36]};

  rbvg_fifo u_fifo (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
  );

  req_t cur;
  always_ff @(posedge clk) if (q_valid && q_ready) cur <= q_req;

  rbvg_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk, .rst, .pixel_scale, .req_valid(q_valid), .req_ready(q_ready),
    .req(q_req), .go, .done, .rad_o(rad), .radi_o(radi), .bs_o(bs),
    .wf_o(wf), .hf_o(hf)
  );

  rbvg_walker #(.ARC_POINTS(ARC_POINTS)) u_walker (
    .clk, .rst, .go, .done, .mask(cur.corner_mask),
    .bw_nz(cur.border_width != 8'd0), .rad, .radi, .bs, .wf, .hf,
    .vld(m_tvalid), .rdy(m_tready), .vtx
  );

  assign m_tdata = {1'b0, vtx.half_end, vtx.outer_y, vtx.outer_x,
                    vtx.inner_y, vtx.inner_x, vtx.vertex_index};
  assign m_tuser = {vtx.outer_valid, vtx.vertex_kind};
  assign m_tlast = vtx.last_item;
endmodule

// ===== rtl/rbvg_fifo.sv =====
// Small request queue between the input port and the set-up unit.
// Depends on rbvg_pkg for req_t.
module rbvg_fifo import rbvg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_data
);
  req_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end
endmodule

// ===== rtl/rbvg_setup.sv =====
// Set-up unit: scales radius and border, clamps both radii, shifts box width and height to fixed point.
// Depends on rbvg_pkg; steps through multiply, clamp and limit states, with both products in the multiply step.
module rbvg_setup import rbvg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [SCALE_W-1:0] pixel_scale,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic go,
  input  logic done,
  output logic signed [31:0] rad_o,
  output logic signed [31:0] radi_o,
  output logic signed [31:0] bs_o,
  output logic signed [31:0] wf_o,
  output logic signed [31:0] hf_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_CLAMP = 3'd2,
                         S_RUN = 3'd3, S_LIMIT = 3'd4;
  logic [2:0] state;
  req_t r;
  logic [21:0] p_rad, p_bs;
  logic signed [31:0] rad, radi, bs, wf, hf, minsize;
  logic tl, tr, br, bl, hone, vone;
  logic [12:0] m1, m2, mn;

  assign tl = r.corner_mask[0];
  assign tr = r.corner_mask[1];
  assign br = r.corner_mask[2];
  assign bl = r.corner_mask[3];
  assign hone = (tl && tr) || (br && bl);
  assign vone = (tl && bl) || (tr && br);
  assign m1 = hone ? {1'b0, r.box_width} : {r.box_width, 1'b0};
  assign m2 = vone ? {1'b0, r.box_height} : {r.box_height, 1'b0};
  assign mn = (m1 < m2) ? m1 : m2;
  assign minsize = 32'(mn) <<< FRAC_BITS;

  assign req_ready = (state == S_IDLE);
  assign go = (state == S_RUN);
  assign rad_o = rad;
  assign radi_o = radi;
  assign bs_o = bs;
  assign wf_o = wf;
  assign hf_o = hf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) begin
          r <= req;
          state <= S_MUL;
        end
        S_MUL: begin
          p_rad <= {12'd0, r.corner_radius} * {10'd0, pixel_scale};
          p_bs  <= {14'd0, r.border_width} * {10'd0, pixel_scale};
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          // scaled = product * 2^F / 256
          rad  <= 32'(({18'd0, p_rad} << FRAC_BITS) >> 8);
          bs   <= 32'(({18'd0, p_bs} << FRAC_BITS) >> 8);
          wf   <= 32'(r.box_width) <<< FRAC_BITS;
          hf   <= 32'(r.box_height) <<< FRAC_BITS;
          state <= S_LIMIT;
        end
        S_LIMIT: begin
          radi <= rad - bs;
          if (2 * rad > minsize) rad <= minsize >>> 1;
          if (2 * (rad - bs + (32'sd1 <<< FRAC_BITS)) > minsize)
            radi <= (minsize >>> 1) - (32'(r.border_width) <<< FRAC_BITS);
          state <= S_RUN;
        end
        S_RUN: if (done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/rbvg_walker.sv =====
// Vertex walker: steps through center, four corners and the closing vertex.
// Depends on rbvg_pkg for the arc table and vtx_t; one multiply stage for the outline vertices.
module rbvg_walker import rbvg_pkg::*; #(
  parameter int ARC_POINTS = ARC_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  output logic done,
  input  logic [3:0] mask,
  input  logic bw_nz,
  input  logic signed [31:0] rad,
  input  logic signed [31:0] radi,
  input  logic signed [31:0] bs,
  input  logic signed [31:0] wf,
  input  logic signed [31:0] hf,
  output logic vld,
  input  logic rdy,
  output vtx_t vtx
);
  localparam logic [1:0] P_CENTER = 2'd0, P_OUTLINE = 2'd1, P_CLOSE = 2'd2,
                         P_HOLD = 2'd3;
  logic [1:0] phase;
  logic [1:0] c;
  logic [3:0] i;
  logic [5:0] k;
  logic busy, stg_v, last_seen;
  logic rounded, corner_end;
  logic signed [COORD_W-1:0] first_ix, first_iy;
  // stage-1 registers
  logic [1:0] s_c;
  logic s_rnd, s_half, s_first;
  logic [5:0] s_k;
  logic signed [47:0] s_ia, s_ib, s_oa, s_ob;
  logic signed [47:0] via, vib, voa, vob, ix, iy, ox, oy;
  logic signed [COORD_W-1:0] cix, ciy;
  logic can;

  assign rounded = mask[3 - c];
  assign corner_end = !rounded || (i == 4'(ARC_POINTS - 1));
  assign can = !vld || rdy;

  function automatic logic signed [47:0] rdiv(input logic signed [47:0] v);
    return (v + 48'sd512) >>> 10;
  endfunction

  assign via = rdiv(s_ia);
  assign vib = rdiv(s_ib);
  assign voa = rdiv(s_oa);
  assign vob = rdiv(s_ob);

  always_comb begin
    unique case (s_c)
      2'd0: begin
        ix = s_rnd ? 48'(bs) + vib : 48'(bs);
        iy = s_rnd ? 48'(bs) + 48'(radi) - via : 48'(bs);
        ox = s_rnd ? vob : 48'sd0;
        oy = s_rnd ? 48'(rad) - voa : 48'sd0;
      end
      2'd1: begin
        ix = s_rnd ? 48'(wf) - 48'(bs) - 48'(radi) + via : 48'(wf) - 48'(bs);
        iy = s_rnd ? 48'(bs) + vib : 48'(bs);
        ox = s_rnd ? 48'(wf) - 48'(rad) + voa : 48'(wf);
        oy = s_rnd ? vob : 48'sd0;
      end
      2'd2: begin
        ix = s_rnd ? 48'(wf) - 48'(bs) - vib : 48'(wf) - 48'(bs);
        iy = s_rnd ? 48'(hf) - 48'(bs) - 48'(radi) + via : 48'(hf) - 48'(bs);
        ox = s_rnd ? 48'(wf) - vob : 48'(wf);
        oy = s_rnd ? 48'(hf) - 48'(rad) + voa : 48'(hf);
      end
      default: begin
        ix = s_rnd ? 48'(bs) + 48'(radi) - via : 48'(bs);
        iy = s_rnd ? 48'(hf) - 48'(bs) - vib : 48'(hf) - 48'(bs);
        ox = s_rnd ? 48'(rad) - voa : 48'sd0;
        oy = s_rnd ? 48'(hf) - vob : 48'(hf);
      end
    endcase
  end

  assign cix = sat_coord((48'(wf) - 48'(bs) - 48'(bs)) / 2);
  assign ciy = sat_coord((48'(hf) - 48'(bs) - 48'(bs)) / 2);
  assign done = busy && last_seen && vld && rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      vld <= 1'b0;
      stg_v <= 1'b0;
      phase <= P_CENTER;
      last_seen <= 1'b0;
    end else begin
      if (vld && rdy) vld <= 1'b0;
      if (done) begin
        busy <= 1'b0;
        last_seen <= 1'b0;
      end
      if (go && !busy && !last_seen) begin
        busy <= 1'b1;
        phase <= P_CENTER;
        c <= 2'd0;
        i <= 4'd0;
        k <= 6'd1;
      end
      if (busy && can) begin
        // stage 2 result
        if (stg_v) begin
          vld <= 1'b1;
          vtx.vertex_kind <= KIND_OUTLINE;
          vtx.vertex_index <= s_k;
          vtx.inner_x <= sat_coord(ix);
          vtx.inner_y <= sat_coord(iy);
          vtx.outer_x <= bw_nz ? sat_coord(ox) : '0;
          vtx.outer_y <= bw_nz ? sat_coord(oy) : '0;
          vtx.outer_valid <= bw_nz;
          vtx.half_end <= s_half;
          vtx.last_item <= 1'b0;
          if (s_first) begin
            first_ix <= sat_coord(ix);
            first_iy <= sat_coord(iy);
          end
          stg_v <= 1'b0;
        end
        unique case (phase)
          P_CENTER: begin
            vld <= 1'b1;
            vtx <= '{KIND_CENTER, 6'd0, cix, ciy, '0, '0, 1'b0, 1'b0, 1'b0};
            phase <= P_OUTLINE;
          end
          P_OUTLINE: begin
            stg_v <= 1'b1;
            s_c <= c;
            s_rnd <= rounded;
            s_k <= k;
            s_first <= (k == 6'd1);
            s_half <= (c == 2'd1) && corner_end;
            s_ia <= 48'(radi) * $signed({1'b0, arc_a(i)});
            s_ib <= 48'(radi) * $signed({1'b0, arc_b(i)});
            s_oa <= 48'(rad) * $signed({1'b0, arc_a(i)});
            s_ob <= 48'(rad) * $signed({1'b0, arc_b(i)});
            k <= k + 6'd1;
            if (corner_end) begin
              i <= 4'd0;
              c <= c + 2'd1;
              if (c == 2'd3) phase <= P_CLOSE;
            end else begin
              i <= i + 4'd1;
            end
          end
          P_CLOSE: if (!stg_v) begin
            vld <= 1'b1;
            vtx <= '{KIND_CLOSE, k, first_ix, first_iy, '0, '0, 1'b0, 1'b0, 1'b1};
            phase <= P_HOLD;
            last_seen <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
